[rtl/expiry_ordered_timer_table_macros.svh]
// Assertion macros shared by the timer table RTL.
`ifndef EXPIRY_ORDERED_TIMER_TABLE_MACROS_SVH
`define EXPIRY_ORDERED_TIMER_TABLE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define EOTT_ASSERT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("timer table assertion failed");

// Next-cycle implication, disabled while in reset.
`define EOTT_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("timer table assertion failed");

`endif

[rtl/eott_pkg.sv]
// Shared types, widths and codes for the timer table.
package eott_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int MAX_SLOTS      = 16;
    localparam int TIME_W         = 32;
    localparam int PERIOD_W       = 31;
    localparam int PER_WORD_W     = PERIOD_W + 1;
    localparam int ID_W           = 4;

    localparam logic [TIME_W-1:0] HALF_RANGE = 32'h7fff_ffff;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CHECK  = 2'd2;

    localparam logic KIND_ACK    = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic              sub;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] operand;
        logic [TIME_W-1:0] best_age;
    } alu_req_t;

    typedef struct packed {
        logic [TIME_W-1:0] sum;
        logic              due;
        logic              older;
    } alu_rsp_t;

    typedef struct packed {
        logic exp_we;
        logic per_we;
        logic vld_set;
        logic vld_clr;
    } store_ctl_t;

    typedef struct packed {
        logic            kind;
        logic            status;
        logic [ID_W-1:0] expired_id;
        logic            last;
    } result_t;

endpackage

[rtl/eott_if.sv]
// Command and result channel interfaces of the timer table.
interface eott_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    opcode;
    logic [eott_pkg::ID_W-1:0]     timer_id;
    logic [eott_pkg::TIME_W-1:0]   now_time;
    logic [eott_pkg::PERIOD_W-1:0] period;
    logic                          reload_enable;

    modport source (
        output valid, opcode, timer_id, now_time, period, reload_enable,
        input  ready
    );
    modport sink (
        input  valid, opcode, timer_id, now_time, period, reload_enable,
        output ready
    );
endinterface

interface eott_out_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic                      status;
    logic [eott_pkg::ID_W-1:0] expired_id;
    logic                      last;

    modport source (
        output valid, kind, status, expired_id, last,
        input  ready
    );
    modport sink (
        input  valid, kind, status, expired_id, last,
        output ready
    );
endinterface

[rtl/eott_alu.sv]
// Shared adder/subtractor with wrap-aware due test and age compare.
module eott_alu (
    input  eott_pkg::alu_req_t req,
    output eott_pkg::alu_rsp_t res
);
    import eott_pkg::*;

    logic [TIME_W-1:0] operand_eff;
    logic [TIME_W-1:0] sum;

    assign operand_eff = req.sub ? ~req.operand : req.operand;
    assign sum         = req.now + operand_eff + TIME_W'(req.sub);

    assign res.sum   = sum;
    assign res.due   = (sum <= HALF_RANGE);
    assign res.older = (sum > req.best_age);
endmodule

[rtl/eott_store.sv]
// Slot storage: valid flags, expiry memory and period/reload memory.
module eott_store #(
    parameter  int SLOT_COUNT = eott_pkg::MAX_SLOTS,
    localparam int IDX_W      = $clog2(SLOT_COUNT)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  eott_pkg::store_ctl_t            ctl,
    input  logic [IDX_W-1:0]                waddr,
    input  logic [eott_pkg::TIME_W-1:0]     exp_wdata,
    input  logic [eott_pkg::PER_WORD_W-1:0] per_wdata,
    input  logic [IDX_W-1:0]                exp_raddr,
    input  logic [IDX_W-1:0]                per_raddr,
    output logic [eott_pkg::TIME_W-1:0]     exp_rdata,
    output logic [eott_pkg::PER_WORD_W-1:0] per_rdata,
    output logic [SLOT_COUNT-1:0]           valid
);
    import eott_pkg::*;

    logic [SLOT_COUNT-1:0] valid_reg;
    logic [SLOT_COUNT-1:0] valid_next;
    logic [TIME_W-1:0]     exp_mem [SLOT_COUNT];
    logic [PER_WORD_W-1:0] per_mem [SLOT_COUNT];
    logic [TIME_W-1:0]     exp_rdata_reg;
    logic [PER_WORD_W-1:0] per_rdata_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.vld_set)
        begin
            valid_next[waddr] = 1'b1;
        end
        if (ctl.vld_clr)
        begin
            valid_next[waddr] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.exp_we)
        begin
            exp_mem[waddr] <= exp_wdata;
        end
        exp_rdata_reg <= exp_mem[exp_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.per_we)
        begin
            per_mem[waddr] <= per_wdata;
        end
        per_rdata_reg <= per_mem[per_raddr];
    end

    assign valid     = valid_reg;
    assign exp_rdata = exp_rdata_reg;
    assign per_rdata = per_rdata_reg;
endmodule

[rtl/expiry_ordered_timer_table.sv]
// Timer table top level: command sequencer, slot store and shared age unit.
//
// Add and remove pass through S_OP and return one acknowledgment word. A check
// scans the expiry memory one slot per cycle through a single subtractor and
// comparator: each scan pass picks the oldest due slot, and each reported slot
// then passes through S_RLD_RD and S_RLD_WR to read its period and re-arm or
// disarm it. The command channel is ready only between commands; a result word
// waits in an output register, and the sequencer stalls before writing a result
// while that register is full and not being read. SLOT_COUNT is NUM_TIMERS
// capped at 16, the reach of timer_id.
`include "expiry_ordered_timer_table_macros.svh"

module expiry_ordered_timer_table #(
    parameter int NUM_TIMERS = eott_pkg::NUM_TIMERS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    eott_in_if.sink    cmd,
    eott_out_if.source rsp
);
    import eott_pkg::*;

    localparam int SLOT_COUNT = (NUM_TIMERS < MAX_SLOTS) ? NUM_TIMERS : MAX_SLOTS;
    localparam int IDX_W      = $clog2(SLOT_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_OP     = 5'b00010,
        S_SCAN   = 5'b00100,
        S_RLD_RD = 5'b01000,
        S_RLD_WR = 5'b10000
    } state_t;

    state_t                state_reg,      state_next;
    logic [1:0]            op_reg,         op_next;
    logic [ID_W-1:0]       id_reg,         id_next;
    logic [TIME_W-1:0]     now_reg,        now_next;
    logic [PERIOD_W-1:0]   period_reg,     period_next;
    logic                  rel_reg,        rel_next;
    logic [IDX_W-1:0]      scan_addr_reg,  scan_addr_next;
    logic                  issue_reg,      issue_next;
    logic                  cmp_vld_reg,    cmp_vld_next;
    logic [IDX_W-1:0]      cmp_idx_reg,    cmp_idx_next;
    logic                  first_reg,      first_next;
    logic                  found_reg,      found_next;
    logic [IDX_W-1:0]      best_idx_reg,   best_idx_next;
    logic [TIME_W-1:0]     best_age_reg,   best_age_next;
    logic [SLOT_COUNT-1:0] due_reg,        due_next;
    logic                  out_valid_reg,  out_valid_next;
    result_t               out_res_reg,    out_res_next;

    alu_req_t              alu_req;
    alu_rsp_t              alu_res;
    store_ctl_t            st_ctl;
    logic [IDX_W-1:0]      st_waddr;
    logic [TIME_W-1:0]     exp_rdata;
    logic [PER_WORD_W-1:0] per_rdata;
    logic [SLOT_COUNT-1:0] valid_vec;

    logic                  cmd_fire;
    logic                  out_free;
    logic                  id_in_range;
    logic [IDX_W-1:0]      id_idx;
    logic                  due_bit;
    logic                  last_report;
    logic                  add_commit;
    logic                  rescan;
    logic                  ack_out;

    eott_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    eott_store #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (st_ctl),
        .waddr     (st_waddr),
        .exp_wdata (alu_res.sum),
        .per_wdata ({rel_reg, period_reg}),
        .exp_raddr (scan_addr_reg),
        .per_raddr (best_idx_reg),
        .exp_rdata (exp_rdata),
        .per_rdata (per_rdata),
        .valid     (valid_vec)
    );

    assign cmd.ready   = (state_reg == S_IDLE);
    assign cmd_fire    = cmd.valid && cmd.ready;
    assign out_free    = !out_valid_reg || rsp.ready;
    assign id_in_range = ({1'b0, id_reg} < (ID_W + 1)'(SLOT_COUNT));
    assign id_idx      = id_reg[IDX_W-1:0];
    assign last_report = (due_reg == '0);

    assign add_commit = (state_reg == S_OP) && (op_reg == OP_ADD) && id_in_range && out_free;
    assign rescan     = (state_reg == S_SCAN) && !first_reg;
    assign ack_out    = out_valid_reg && (out_res_reg.kind == KIND_ACK);

    assign rsp.valid      = out_valid_reg;
    assign rsp.kind       = out_res_reg.kind;
    assign rsp.status     = out_res_reg.status;
    assign rsp.expired_id = out_res_reg.expired_id;
    assign rsp.last       = out_res_reg.last;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        now_next       = now_reg;
        period_next    = period_reg;
        rel_next       = rel_reg;
        scan_addr_next = scan_addr_reg;
        issue_next     = issue_reg;
        cmp_vld_next   = cmp_vld_reg;
        cmp_idx_next   = cmp_idx_reg;
        first_next     = first_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_age_next  = best_age_reg;
        due_next       = due_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        due_bit        = 1'b0;

        alu_req.sub      = 1'b0;
        alu_req.now      = now_reg;
        alu_req.operand  = {1'b0, period_reg};
        alu_req.best_age = best_age_reg;

        st_ctl   = '0;
        st_waddr = id_idx;

        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    op_next     = cmd.opcode;
                    id_next     = cmd.timer_id;
                    now_next    = cmd.now_time;
                    period_next = cmd.period;
                    rel_next    = cmd.reload_enable;
                    priority if (cmd.opcode == OP_ADD || cmd.opcode == OP_REMOVE)
                    begin
                        state_next = S_OP;
                    end
                    else if (cmd.opcode == OP_CHECK)
                    begin
                        state_next     = S_SCAN;
                        scan_addr_next = '0;
                        issue_next     = 1'b1;
                        cmp_vld_next   = 1'b0;
                        first_next     = 1'b1;
                        found_next     = 1'b0;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_OP:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_res_next.kind       = KIND_ACK;
                    out_res_next.expired_id = id_reg;
                    out_res_next.last       = 1'b1;
                    if (op_reg == OP_ADD)
                    begin
                        st_ctl.exp_we       = id_in_range;
                        st_ctl.per_we       = id_in_range;
                        st_ctl.vld_set      = id_in_range;
                        out_res_next.status = id_in_range ? STATUS_OK : STATUS_FAIL;
                    end
                    else
                    begin
                        st_ctl.vld_clr      = id_in_range;
                        out_res_next.status = (id_in_range && valid_vec[id_idx])
                                              ? STATUS_OK : STATUS_FAIL;
                    end
                    state_next = S_IDLE;
                end
            end

            S_SCAN:
            begin
                alu_req.sub     = 1'b1;
                alu_req.operand = exp_rdata;
                cmp_vld_next    = issue_reg;
                cmp_idx_next    = scan_addr_reg;
                if (issue_reg)
                begin
                    scan_addr_next = scan_addr_reg + 1'b1;
                    if (scan_addr_reg == LAST_IDX)
                    begin
                        issue_next = 1'b0;
                    end
                end
                if (cmp_vld_reg)
                begin
                    due_bit = first_reg ? (valid_vec[cmp_idx_reg] && alu_res.due)
                                        : due_reg[cmp_idx_reg];
                    if (first_reg)
                    begin
                        due_next[cmp_idx_reg] = due_bit;
                    end
                    if (due_bit && (!found_reg || alu_res.older))
                    begin
                        found_next    = 1'b1;
                        best_idx_next = cmp_idx_reg;
                        best_age_next = alu_res.sum;
                    end
                    if (cmp_idx_reg == LAST_IDX)
                    begin
                        state_next = found_next ? S_RLD_RD : S_IDLE;
                    end
                end
            end

            S_RLD_RD:
            begin
                due_next[best_idx_reg] = 1'b0;
                state_next             = S_RLD_WR;
            end

            S_RLD_WR:
            begin
                alu_req.operand = {1'b0, per_rdata[PERIOD_W-1:0]};
                if (out_free)
                begin
                    st_waddr       = best_idx_reg;
                    st_ctl.exp_we  = per_rdata[PERIOD_W];
                    st_ctl.vld_clr = !per_rdata[PERIOD_W];
                    out_valid_next          = 1'b1;
                    out_res_next.kind       = KIND_EXPIRY;
                    out_res_next.status     = STATUS_OK;
                    out_res_next.expired_id = ID_W'(best_idx_reg);
                    out_res_next.last       = last_report;
                    if (last_report)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next     = S_SCAN;
                        scan_addr_next = '0;
                        issue_next     = 1'b1;
                        cmp_vld_next   = 1'b0;
                        first_next     = 1'b0;
                        found_next     = 1'b0;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issue_reg     <= 1'b0;
            cmp_vld_reg   <= 1'b0;
            first_reg     <= 1'b0;
            found_reg     <= 1'b0;
            due_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            cmp_vld_reg   <= cmp_vld_next;
            first_reg     <= first_next;
            found_reg     <= found_next;
            due_reg       <= due_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        id_reg        <= id_next;
        now_reg       <= now_next;
        period_reg    <= period_next;
        rel_reg       <= rel_next;
        scan_addr_reg <= scan_addr_next;
        cmp_idx_reg   <= cmp_idx_next;
        best_idx_reg  <= best_idx_next;
        best_age_reg  <= best_age_next;
        out_res_reg   <= out_res_next;
    end

    `EOTT_ASSERT_NEXT(a_add_arms_slot, clk, rst_n, add_commit, valid_vec[id_idx])
    `EOTT_ASSERT(a_report_is_armed, clk, rst_n, state_reg == S_RLD_WR, valid_vec[best_idx_reg])
    `EOTT_ASSERT(a_due_subset_armed, clk, rst_n, rescan, (due_reg & ~valid_vec) == '0)
    `EOTT_ASSERT(a_ack_is_last, clk, rst_n, ack_out, out_res_reg.last)
endmodule
